/* rtl/soe_pkg.sv */
`default_nettype none
package soe_pkg;

    localparam int SET_SIZE    = 16;
    localparam int MAX_RESULTS = 32;
    localparam int VAL_W       = 16;
    localparam int SIZE_W      = 6;
    localparam int AW          = $clog2(SET_SIZE);
    localparam int CW          = $clog2(SET_SIZE + 1);
    localparam int FLAGS       = 2 * SET_SIZE;
    localparam int KW          = $clog2(FLAGS);

    localparam logic [2:0] REQ_LOAD_A = 3'd0;
    localparam logic [2:0] REQ_LOAD_B = 3'd1;
    localparam logic [2:0] REQ_LOAD_U = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [2:0] OP_INTERSECT = 3'd0;
    localparam logic [2:0] OP_A_MINUS_B = 3'd1;
    localparam logic [2:0] OP_B_MINUS_A = 3'd2;
    localparam logic [2:0] OP_UNION     = 3'd3;
    localparam logic [2:0] OP_NEITHER   = 3'd4;

    typedef enum logic [1:0] {
        ST_A,
        ST_B,
        ST_U
    } t_store;

    typedef enum logic [1:0] {
        KEEP_HIT_B,
        KEEP_NO_B,
        KEEP_NO_A,
        KEEP_NO_AB
    } t_keep;

    typedef struct packed {
        logic             load_en;
        t_store           load_sel;
        logic [VAL_W-1:0] load_value;
        logic             clear;
        logic             start;
        logic             fill_a;
        t_store           cand_sel;
        logic [AW-1:0]    cand_addr;
        logic [AW-1:0]    cmp_addr;
        logic             issue_a;
        logic             issue_b;
        logic             decide;
        t_keep            keep;
        logic [KW-1:0]    flag_idx;
        logic             out_load;
        logic             out_empty;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0]     cnt_a;
        logic [CW-1:0]     cnt_b;
        logic [CW-1:0]     cnt_u;
        logic              flag_k;
        logic [SIZE_W-1:0] size;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/soe_ram.sv */
`default_nettype none
module soe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/soe_datapath.sv */
`default_nettype none
module soe_datapath
    import soe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic [VAL_W-1:0]       o_member_value,
    output logic                   o_result_empty,
    output logic [SIZE_W-1:0]      o_result_size,
    output logic                   o_overflow_seen
);

    logic [CW-1:0]     r_cnt_a, r_cnt_b, r_cnt_u;
    logic              r_overflow;
    logic              r_en_a_d, r_en_b_d;
    logic              r_hit_a, r_hit_b;
    logic [FLAGS-1:0]  r_flags;
    logic [SIZE_W-1:0] r_size;
    logic [VAL_W-1:0]  r_member;
    logic              r_empty;

    logic [VAL_W-1:0]  q_a, q_b, q_u, cand_q;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic              we_a, we_b, we_u;
    logic              hit_a_n, hit_b_n, keep;
    logic              full_a, full_b, full_u;

    assign full_a = (r_cnt_a == CW'(SET_SIZE));
    assign full_b = (r_cnt_b == CW'(SET_SIZE));
    assign full_u = (r_cnt_u == CW'(SET_SIZE));

    assign we_a = i_cmd.load_en && (i_cmd.load_sel == ST_A) && !full_a;
    assign we_b = i_cmd.load_en && (i_cmd.load_sel == ST_B) && !full_b;
    assign we_u = i_cmd.load_en && (i_cmd.load_sel == ST_U) && !full_u;

    assign raddr_a = (i_cmd.cand_sel == ST_A) ? i_cmd.cand_addr : i_cmd.cmp_addr;
    assign raddr_b = (i_cmd.cand_sel == ST_B) ? i_cmd.cand_addr : i_cmd.cmp_addr;

    soe_ram #(.WIDTH(VAL_W), .DEPTH(SET_SIZE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_cmd.load_value),
        .i_raddr (raddr_a),
        .o_rdata (q_a)
    );

    soe_ram #(.WIDTH(VAL_W), .DEPTH(SET_SIZE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_cmd.load_value),
        .i_raddr (raddr_b),
        .o_rdata (q_b)
    );

    soe_ram #(.WIDTH(VAL_W), .DEPTH(SET_SIZE)) u_ram_u (
        .i_clk   (i_clk),
        .i_we    (we_u),
        .i_waddr (r_cnt_u[AW-1:0]),
        .i_wdata (i_cmd.load_value),
        .i_raddr (i_cmd.cand_addr),
        .o_rdata (q_u)
    );

    always_comb begin
        unique case (i_cmd.cand_sel)
            ST_A:    cand_q = q_a;
            ST_B:    cand_q = q_b;
            default: cand_q = q_u;
        endcase
    end

    assign hit_a_n = r_hit_a | (r_en_a_d && (cand_q == q_a));
    assign hit_b_n = r_hit_b | (r_en_b_d && (cand_q == q_b));

    always_comb begin
        unique case (i_cmd.keep)
            KEEP_HIT_B: keep = hit_b_n;
            KEEP_NO_B:  keep = !hit_b_n;
            KEEP_NO_A:  keep = !hit_a_n;
            default:    keep = !hit_a_n && !hit_b_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_cnt_u    <= '0;
            r_overflow <= 1'b0;
            r_en_a_d   <= 1'b0;
            r_en_b_d   <= 1'b0;
        end else begin
            r_en_a_d <= i_cmd.issue_a;
            r_en_b_d <= i_cmd.issue_b;
            if (i_cmd.clear) begin
                r_cnt_a    <= '0;
                r_cnt_b    <= '0;
                r_cnt_u    <= '0;
                r_overflow <= 1'b0;
            end else if (i_cmd.load_en) begin
                unique case (i_cmd.load_sel)
                    ST_A: begin
                        if (full_a) r_overflow <= 1'b1;
                        else        r_cnt_a    <= r_cnt_a + CW'(1);
                    end
                    ST_B: begin
                        if (full_b) r_overflow <= 1'b1;
                        else        r_cnt_b    <= r_cnt_b + CW'(1);
                    end
                    default: begin
                        if (full_u) r_overflow <= 1'b1;
                        else        r_cnt_u    <= r_cnt_u + CW'(1);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_flags <= '0;
            r_size  <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else if (i_cmd.fill_a) begin
            for (int k = 0; k < SET_SIZE; k++) begin
                r_flags[k] <= (CW'(k) < r_cnt_a);
            end
            r_size <= SIZE_W'(r_cnt_a);
        end else if (i_cmd.decide) begin
            r_flags[i_cmd.flag_idx] <= keep;
            if (keep && (r_size < SIZE_W'(MAX_RESULTS))) begin
                r_size <= r_size + SIZE_W'(1);
            end
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            r_hit_a <= hit_a_n;
            r_hit_b <= hit_b_n;
        end
        if (i_cmd.out_load) begin
            r_member <= i_cmd.out_empty ? '0 : cand_q;
            r_empty  <= i_cmd.out_empty;
        end
    end

    assign o_stat.cnt_a  = r_cnt_a;
    assign o_stat.cnt_b  = r_cnt_b;
    assign o_stat.cnt_u  = r_cnt_u;
    assign o_stat.flag_k = r_flags[i_cmd.flag_idx];
    assign o_stat.size   = r_size;

    assign o_member_value  = r_member;
    assign o_result_empty  = r_empty;
    assign o_result_size   = r_size;
    assign o_overflow_seen = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(SET_SIZE)) && (r_cnt_b <= CW'(SET_SIZE)) &&
        (r_cnt_u <= CW'(SET_SIZE)))
        else $error("store count beyond capacity");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow && !i_cmd.clear |=> r_overflow)
        else $error("overflow flag dropped without clear");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_en && !i_cmd.clear && (i_cmd.load_sel == ST_A) && full_a
        |=> r_overflow && (r_cnt_a == CW'(SET_SIZE)))
        else $error("load into full store not dropped");

endmodule
`default_nettype wire

/* rtl/soe_controller.sv */
`default_nettype none
module soe_controller
    import soe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [2:0]       i_req_type,
    input  wire logic [VAL_W-1:0] i_element_value,
    input  wire logic [2:0]       i_operation,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_last_item,
    output t_cmd                  o_cmd,
    input  wire t_stat            i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_PREP,
        S_SCAN,
        S_DECIDE,
        S_EMIT,
        S_FETCH,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [CW-1:0]     r_i, n_i, r_j, n_j;
    logic [KW-1:0]     r_k, n_k;
    logic [SIZE_W-1:0] r_emitted, n_emitted;
    logic              r_last, n_last;

    logic [CW-1:0]     cand_cnt, cmp_len;
    logic              cmp_a_used, cmp_b_used;
    t_store            scan_sel, em_sel;
    t_keep             keep_mode;
    logic              em_second;
    logic [AW-1:0]     em_addr;
    logic              in_acc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        unique case (r_op) inside
            OP_INTERSECT, OP_A_MINUS_B: begin
                cand_cnt   = i_stat.cnt_a;
                cmp_len    = i_stat.cnt_b;
                cmp_a_used = 1'b0;
                cmp_b_used = 1'b1;
                scan_sel   = ST_A;
                keep_mode  = (r_op == OP_INTERSECT) ? KEEP_HIT_B : KEEP_NO_B;
            end
            OP_B_MINUS_A, OP_UNION: begin
                cand_cnt   = i_stat.cnt_b;
                cmp_len    = i_stat.cnt_a;
                cmp_a_used = 1'b1;
                cmp_b_used = 1'b0;
                scan_sel   = ST_B;
                keep_mode  = KEEP_NO_A;
            end
            default: begin
                cand_cnt   = i_stat.cnt_u;
                cmp_len    = (i_stat.cnt_a > i_stat.cnt_b) ? i_stat.cnt_a : i_stat.cnt_b;
                cmp_a_used = 1'b1;
                cmp_b_used = 1'b1;
                scan_sel   = ST_U;
                keep_mode  = KEEP_NO_AB;
            end
        endcase
    end

    assign em_second = (r_k >= KW'(SET_SIZE));
    assign em_addr   = em_second ? AW'(r_k - KW'(SET_SIZE)) : AW'(r_k);

    always_comb begin
        unique case (r_op) inside
            OP_INTERSECT, OP_A_MINUS_B: em_sel = ST_A;
            OP_B_MINUS_A:               em_sel = ST_B;
            OP_UNION:                   em_sel = em_second ? ST_B : ST_A;
            default:                    em_sel = ST_U;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_emitted = r_emitted;
        n_last    = r_last;

        o_cmd            = '0;
        o_cmd.load_value = i_element_value;
        o_cmd.keep       = keep_mode;
        o_cmd.cand_sel   = scan_sel;
        o_cmd.cand_addr  = r_i[AW-1:0];
        o_cmd.cmp_addr   = r_j[AW-1:0];
        o_cmd.flag_idx   = (r_op == OP_UNION) ? KW'(SET_SIZE) + KW'(r_i) : KW'(r_i);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req_type)
                        REQ_LOAD_A: begin
                            o_cmd.load_en  = 1'b1;
                            o_cmd.load_sel = ST_A;
                        end
                        REQ_LOAD_B: begin
                            o_cmd.load_en  = 1'b1;
                            o_cmd.load_sel = ST_B;
                        end
                        REQ_LOAD_U: begin
                            o_cmd.load_en  = 1'b1;
                            o_cmd.load_sel = ST_U;
                        end
                        REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        REQ_QUERY: begin
                            if (i_operation <= OP_NEITHER) begin
                                o_cmd.start = 1'b1;
                                n_op        = i_operation;
                                n_state     = (i_operation == OP_UNION) ? S_FILL : S_PREP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_a = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                n_i       = '0;
                n_j       = '0;
                n_k       = '0;
                n_emitted = '0;
                n_state   = (cand_cnt == '0) ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.issue_a = cmp_a_used && (r_j < i_stat.cnt_a);
                o_cmd.issue_b = cmp_b_used && (r_j < i_stat.cnt_b);
                n_j           = r_j + CW'(1);
                if (n_j >= cmp_len) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_j          = '0;
                if ((r_i + CW'(1)) >= cand_cnt) begin
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                o_cmd.cand_sel  = em_sel;
                o_cmd.cand_addr = em_addr;
                o_cmd.flag_idx  = r_k;
                if (i_stat.size == '0) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    n_last          = 1'b1;
                    n_state         = S_OUT;
                end else if (i_stat.flag_k) begin
                    n_state = S_FETCH;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_FETCH: begin
                o_cmd.cand_sel  = em_sel;
                o_cmd.cand_addr = em_addr;
                o_cmd.flag_idx  = r_k;
                o_cmd.out_load  = 1'b1;
                n_last          = ((r_emitted + SIZE_W'(1)) == i_stat.size);
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_cmd.cand_sel  = em_sel;
                o_cmd.cand_addr = em_addr;
                o_cmd.flag_idx  = r_k;
                if (i_out_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k       = r_k + KW'(1);
                        n_emitted = r_emitted + SIZE_W'(1);
                        n_state   = S_EMIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op      <= n_op;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_emitted <= n_emitted;
        r_last    <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_last_item = r_last;

    a_decide_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |-> $past(r_state) == S_SCAN)
        else $error("decide step without a compare scan");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && (i_stat.size != '0) |-> r_emitted < i_stat.size)
        else $error("more members emitted than result size");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_item |=> o_in_ready)
        else $error("not idle after final transfer");

endmodule
`default_nettype wire

/* rtl/set_operation_engine.sv */
// loads and clear: no result; the next item is taken in the following cycle
// query: each candidate entry passes the compare scan and a decide step, then each member
// passes emit, fetch and output, a skipped entry emit only; one read port per store
// a query with no members gives one empty transfer
// reset is synchronous, active low: store counts, overflow flag and controller state cleared,
// store contents are left as they are
`default_nettype none
module set_operation_engine
    import soe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [VAL_W-1:0]  i_element_value,
    input  wire logic [2:0]        i_operation,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [VAL_W-1:0]       o_member_value,
    output logic                   o_result_empty,
    output logic [SIZE_W-1:0]      o_result_size,
    output logic                   o_overflow_seen,
    output logic                   o_last_item
);

    t_cmd  cmd;
    t_stat stat;

    soe_controller u_controller (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_element_value (i_element_value),
        .i_operation     (i_operation),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_last_item     (o_last_item),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    soe_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_member_value  (o_member_value),
        .o_result_empty  (o_result_empty),
        .o_result_size   (o_result_size),
        .o_overflow_seen (o_overflow_seen)
    );

endmodule
`default_nettype wire
